[src/slave_link_health_tracker_core_assert.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the slave link health tracker.
// Concurrent checks that compile away when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef SLAVE_LINK_HEALTH_TRACKER_CORE_ASSERT_SVH
`define SLAVE_LINK_HEALTH_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on the rising clock edge, disabled while reset is active.
`define SLHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on the rising clock edge, also during reset.
`define SLHT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SLHT_ASSERT(label, clk, rst_n, prop, msg)
`define SLHT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[src/slht_pkg.sv]
// -----------------------------------------------------------------------------
// slht_pkg
// Shared types, codes and defaults of the slave link health tracker.
// -----------------------------------------------------------------------------
package slht_pkg;

    // Default sizing of the device table.
    localparam int DEVICES_DEFAULT  = 8;
    localparam int CHANNELS_DEFAULT = 8;

    // Fixed field widths of the poll report, the result and the limits.
    localparam int DEV_IDX_W  = 3;
    localparam int CHAN_IDX_W = 3;
    localparam int CNT_W      = 32;
    localparam int MASK_OUT_W = 8;
    localparam int LIMIT_W    = 16;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] OFFLINE_LIMIT_RESET  = 16'd3;
    localparam logic [LIMIT_W-1:0] RECOVERY_LIMIT_RESET = 16'd1;

    // Register indexes, taken from paddr[2].
    typedef enum logic
    {
        REG_OFFLINE_FAILURE_LIMIT  = 1'b0,
        REG_RECOVERY_SUCCESS_LIMIT = 1'b1
    } reg_index_t;

    // Poll outcome codes; the unused code counts as an exception.
    typedef enum logic [1:0]
    {
        OUTCOME_SUCCESS   = 2'd0,
        OUTCOME_TIMEOUT   = 2'd1,
        OUTCOME_EXCEPTION = 2'd2
    } outcome_t;

    // Limits held by the configuration registers.
    typedef struct packed
    {
        logic [LIMIT_W-1:0] offline_failure;
        logic [LIMIT_W-1:0] recovery_success;
    } limits_t;

    // Per-device counters and online flag.
    typedef struct packed
    {
        logic             online;
        logic [CNT_W-1:0] failure_run;
        logic [CNT_W-1:0] success_run;
        logic [CNT_W-1:0] success_total;
        logic [CNT_W-1:0] failure_total;
        logic [CNT_W-1:0] timeout_total;
        logic [CNT_W-1:0] exception_total;
    } dev_cnt_t;

    // Result of one transaction, apart from the channel mask.
    typedef struct packed
    {
        logic     rise;
        logic     fall;
        dev_cnt_t cnt;
    } result_t;

endpackage

[src/slht_cfg_regs.sv]
// -----------------------------------------------------------------------------
// slht_cfg_regs
// APB register file holding the offline and recovery limits.
// -----------------------------------------------------------------------------
module slht_cfg_regs
    import slht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output limits_t           limits
);

    limits_t    limits_reg;
    logic       wr_en;
    reg_index_t reg_sel;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[2]);

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.offline_failure  <= OFFLINE_LIMIT_RESET;
            limits_reg.recovery_success <= RECOVERY_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_OFFLINE_FAILURE_LIMIT:  limits_reg.offline_failure  <= pwdata[LIMIT_W-1:0];
                REG_RECOVERY_SUCCESS_LIMIT: limits_reg.recovery_success <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data path.
    always_comb
    begin
        case (reg_sel)
            REG_OFFLINE_FAILURE_LIMIT:
                prdata = APB_DW'(limits_reg.offline_failure);
            REG_RECOVERY_SUCCESS_LIMIT:
                prdata = APB_DW'(limits_reg.recovery_success);
            default:
                prdata = '0;
        endcase
    end

    assign limits = limits_reg;

endmodule

[src/slht_update.sv]
// -----------------------------------------------------------------------------
// slht_update
// Next-state logic of one device for one poll outcome.
// -----------------------------------------------------------------------------
module slht_update
    import slht_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT,
    parameter int MASK_W   = (CHANNELS < MASK_OUT_W) ? CHANNELS : MASK_OUT_W
)
(
    input  dev_cnt_t              cur,
    input  logic     [MASK_W-1:0] cur_mask,
    input  logic [CHAN_IDX_W-1:0] channel,
    input  outcome_t              outcome,
    input  limits_t               limits,
    output dev_cnt_t              nxt,
    output logic     [MASK_W-1:0] nxt_mask,
    output logic                  rise,
    output logic                  fall
);

    logic              chan_ok;
    logic [MASK_W-1:0] chan_bit;

    // Valid bit of the polled channel, if the channel exists.
    assign chan_ok  = 32'(channel) < 32'(CHANNELS);
    assign chan_bit = chan_ok ? (MASK_W'(1) << channel) : '0;

    // Counter updates and online transitions.
    always_comb
    begin
        nxt      = cur;
        nxt_mask = cur_mask;
        rise     = 1'b0;
        fall     = 1'b0;
        if (outcome == OUTCOME_SUCCESS)
        begin
            nxt.success_total = cur.success_total + 1'b1;
            nxt.failure_run   = '0;
            nxt.success_run   = cur.success_run + 1'b1;
            nxt_mask          = cur_mask | chan_bit;
            if (!cur.online && (nxt.success_run >= CNT_W'(limits.recovery_success)))
            begin
                nxt.online = 1'b1;
                rise       = 1'b1;
            end
        end
        else
        begin
            nxt.failure_total = cur.failure_total + 1'b1;
            nxt.failure_run   = cur.failure_run + 1'b1;
            nxt.success_run   = '0;
            case (outcome)
                OUTCOME_TIMEOUT: nxt.timeout_total   = cur.timeout_total + 1'b1;
                default:         nxt.exception_total = cur.exception_total + 1'b1;
            endcase
            if (cur.online && (nxt.failure_run >= CNT_W'(limits.offline_failure)))
            begin
                nxt.online = 1'b0;
                nxt_mask   = '0;
                fall       = 1'b1;
            end
        end
    end

endmodule

[src/slave_link_health_tracker_core.sv]
// -----------------------------------------------------------------------------
// slave_link_health_tracker_core
// Per-device link health counters and online tracking for polled bus slaves.
// -----------------------------------------------------------------------------
// Path: an accepted poll report goes to the input register, then through a
// combinational read-modify-write of the per-device state into the result register.
// Throughput: one transaction per cycle unless a full result slot with out_ready low stalls it.
// Reset: all device counters, online flags and channel valid bits clear at once,
// and the limits return to 3 failures and 1 success.
// -----------------------------------------------------------------------------
`include "slave_link_health_tracker_core_assert.svh"

module slave_link_health_tracker_core
    import slht_pkg::*;
#(
    parameter int DEVICES  = DEVICES_DEFAULT,
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic     [APB_AW-1:0] paddr,
    input  logic     [APB_DW-1:0] pwdata,
    output logic     [APB_DW-1:0] prdata,
    output logic                  pready,
    // Poll report channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic  [DEV_IDX_W-1:0] device_index,
    input  logic [CHAN_IDX_W-1:0] channel_index,
    input  logic            [1:0] outcome,
    // Result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  device_online,
    output logic                  became_online,
    output logic                  went_offline,
    output logic      [CNT_W-1:0] failure_run,
    output logic      [CNT_W-1:0] success_run,
    output logic      [CNT_W-1:0] success_total,
    output logic      [CNT_W-1:0] failure_total,
    output logic      [CNT_W-1:0] timeout_total,
    output logic      [CNT_W-1:0] exception_total,
    output logic [MASK_OUT_W-1:0] channel_valid_mask
);

    // Only eight devices and channels can be addressed by the report fields.
    localparam int DEV_MAX   = 1 << DEV_IDX_W;
    localparam int DEV_DEPTH = (DEVICES < DEV_MAX) ? DEVICES : DEV_MAX;
    localparam int DEV_IW    = (DEV_DEPTH > 1) ? $clog2(DEV_DEPTH) : 1;
    localparam int MASK_W    = (CHANNELS < MASK_OUT_W) ? CHANNELS : MASK_OUT_W;

    limits_t               limits;

    logic                  in_valid_reg;
    logic  [DEV_IDX_W-1:0] dev_in_reg;
    logic [CHAN_IDX_W-1:0] chan_in_reg;
    logic            [1:0] outcome_in_reg;

    dev_cnt_t              cnt_reg  [DEV_DEPTH];
    logic     [MASK_W-1:0] mask_reg [DEV_DEPTH];

    logic                  out_valid_reg;
    result_t               res_reg;
    logic [MASK_OUT_W-1:0] res_mask_reg;

    logic                  advance;
    logic                  dev_ok;
    logic     [DEV_IW-1:0] dev_idx;
    dev_cnt_t              cur_cnt;
    logic     [MASK_W-1:0] cur_mask;
    dev_cnt_t              nxt_cnt;
    logic     [MASK_W-1:0] nxt_mask;
    logic                  rise;
    logic                  fall;
    result_t               res_next;
    logic [MASK_OUT_W-1:0] res_mask_next;

    // Configuration registers.
    slht_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    // Handshake: the held report moves on whenever the result slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dev_in_reg     <= device_index;
            chan_in_reg    <= channel_index;
            outcome_in_reg <= outcome;
        end
    end

    // State read for the addressed device; devices past the table read as zero.
    assign dev_ok  = 32'(dev_in_reg) < 32'(DEVICES);
    assign dev_idx = dev_in_reg[DEV_IW-1:0];

    always_comb
    begin
        cur_cnt  = '0;
        cur_mask = '0;
        if (dev_ok)
        begin
            cur_cnt  = cnt_reg[dev_idx];
            cur_mask = mask_reg[dev_idx];
        end
    end

    slht_update #(
        .CHANNELS (CHANNELS),
        .MASK_W   (MASK_W)
    ) u_update (
        .cur      (cur_cnt),
        .cur_mask (cur_mask),
        .channel  (chan_in_reg),
        .outcome  (outcome_t'(outcome_in_reg)),
        .limits   (limits),
        .nxt      (nxt_cnt),
        .nxt_mask (nxt_mask),
        .rise     (rise),
        .fall     (fall)
    );

    // Per-device state write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEV_DEPTH; i++)
            begin
                cnt_reg[i]  <= '0;
                mask_reg[i] <= '0;
            end
        end
        else if (advance && dev_ok)
        begin
            cnt_reg[dev_idx]  <= nxt_cnt;
            mask_reg[dev_idx] <= nxt_mask;
        end
    end

    // Result formation; an unknown device gives an all-zero result.
    always_comb
    begin
        res_next      = '0;
        res_mask_next = '0;
        if (dev_ok)
        begin
            res_next.rise = rise;
            res_next.fall = fall;
            res_next.cnt  = nxt_cnt;
            res_mask_next = MASK_OUT_W'(nxt_mask);
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg      <= res_next;
            res_mask_reg <= res_mask_next;
        end
    end

    // Output ports.
    assign out_valid          = out_valid_reg;
    assign device_online      = res_reg.cnt.online;
    assign became_online      = res_reg.rise;
    assign went_offline       = res_reg.fall;
    assign failure_run        = res_reg.cnt.failure_run;
    assign success_run        = res_reg.cnt.success_run;
    assign success_total      = res_reg.cnt.success_total;
    assign failure_total      = res_reg.cnt.failure_total;
    assign timeout_total      = res_reg.cnt.timeout_total;
    assign exception_total    = res_reg.cnt.exception_total;
    assign channel_valid_mask = res_mask_reg;

    // A device that just came online reports itself online.
    `SLHT_ASSERT(a_rise_online, clk, rst_n, out_valid_reg && res_reg.rise |-> res_reg.cnt.online, "became_online without device_online")

    // A device that just went offline reports offline with no valid channels.
    `SLHT_ASSERT(a_fall_cleared, clk, rst_n, out_valid_reg && res_reg.fall |-> !res_reg.cnt.online && res_mask_reg == '0, "went_offline with stale state")

    // An empty result slot never holds back the input side.
    `SLHT_ASSERT_ALWAYS(a_ready_when_empty, clk, !out_valid_reg |-> in_ready, "input stalled with empty result slot")

    // A success on a known device clears the failure run in the next result.
    `SLHT_ASSERT(a_success_clears_run, clk, rst_n, advance && dev_ok && outcome_in_reg == OUTCOME_SUCCESS |=> out_valid_reg && res_reg.cnt.failure_run == '0, "failure run not cleared by success")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for slave_link_health_tracker_core
// Drives poll reports through the valid/ready input channel, predicts each
// device's counters, online flag and channel mask in a local model of the
// tracker, and compares every result transaction field by field. The limits
// are reprogrammed over APB between phases, including both extremes.
// ----------------------------------------------------------------------------
module testbench
    import slht_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DEVICES = DEVICES_DEFAULT;
    // The spare outcome code, which the tracker counts as an exception.
    localparam logic [1:0] OUTCOME_SPARE = 2'd3;

    typedef struct packed
    {
        logic [DEV_IDX_W-1:0]  dev;
        logic [CHAN_IDX_W-1:0] chan;
        logic [1:0]            code;
    } poll_t;

    typedef struct packed
    {
        logic                  online;
        logic                  rise;
        logic                  fall;
        logic [CNT_W-1:0]      failure_run;
        logic [CNT_W-1:0]      success_run;
        logic [CNT_W-1:0]      success_total;
        logic [CNT_W-1:0]      failure_total;
        logic [CNT_W-1:0]      timeout_total;
        logic [CNT_W-1:0]      exception_total;
        logic [MASK_OUT_W-1:0] mask;
    } health_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [DEV_IDX_W-1:0]  device_index = '0;
    logic [CHAN_IDX_W-1:0] channel_index = '0;
    logic [1:0]            outcome = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  device_online;
    logic                  became_online;
    logic                  went_offline;
    logic [CNT_W-1:0]      failure_run;
    logic [CNT_W-1:0]      success_run;
    logic [CNT_W-1:0]      success_total;
    logic [CNT_W-1:0]      failure_total;
    logic [CNT_W-1:0]      timeout_total;
    logic [CNT_W-1:0]      exception_total;
    logic [MASK_OUT_W-1:0] channel_valid_mask;

    // Stimulus and scoreboard storage.
    poll_t   pending_polls[$];
    health_t expected_health[$];
    poll_t   current_poll;
    int      fault_count = 0;
    bit      steady = 1'b0;

    // Local copy of the limits and of the per-device tracker state.
    logic [LIMIT_W-1:0]    offline_limit = OFFLINE_LIMIT_RESET;
    logic [LIMIT_W-1:0]    recovery_limit = RECOVERY_LIMIT_RESET;
    logic                  dev_online[NUM_DEVICES];
    logic [CNT_W-1:0]      dev_fail_run[NUM_DEVICES];
    logic [CNT_W-1:0]      dev_pass_run[NUM_DEVICES];
    logic [CNT_W-1:0]      dev_pass_total[NUM_DEVICES];
    logic [CNT_W-1:0]      dev_fail_total[NUM_DEVICES];
    logic [CNT_W-1:0]      dev_timeout_total[NUM_DEVICES];
    logic [CNT_W-1:0]      dev_exception_total[NUM_DEVICES];
    logic [MASK_OUT_W-1:0] dev_mask[NUM_DEVICES];

    slave_link_health_tracker_core dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .device_index       (device_index),
        .channel_index      (channel_index),
        .outcome            (outcome),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .device_online      (device_online),
        .became_online      (became_online),
        .went_offline       (went_offline),
        .failure_run        (failure_run),
        .success_run        (success_run),
        .success_total      (success_total),
        .failure_total      (failure_total),
        .timeout_total      (timeout_total),
        .exception_total    (exception_total),
        .channel_valid_mask (channel_valid_mask)
    );

    always #5 clk = ~clk;

    // All devices start offline with cleared counters.
    initial
    begin
        for (int d = 0; d < NUM_DEVICES; d++)
        begin
            dev_online[d] = 1'b0;
            dev_fail_run[d] = '0;
            dev_pass_run[d] = '0;
            dev_pass_total[d] = '0;
            dev_fail_total[d] = '0;
            dev_timeout_total[d] = '0;
            dev_exception_total[d] = '0;
            dev_mask[d] = '0;
        end
    end

    // Applies one poll report to the local state and returns the device status.
    function automatic health_t predict_health(poll_t p);
        health_t h;
        int      d;
        d = int'(p.dev);
        h = '0;
        if (p.code == OUTCOME_SUCCESS)
        begin
            dev_pass_total[d] += 1;
            dev_fail_run[d] = '0;
            dev_pass_run[d] += 1;
            dev_mask[d][p.chan] = 1'b1;
            if (!dev_online[d] && dev_pass_run[d] >= {16'd0, recovery_limit})
            begin
                dev_online[d] = 1'b1;
                h.rise = 1'b1;
            end
        end
        else
        begin
            dev_fail_total[d] += 1;
            dev_fail_run[d] += 1;
            dev_pass_run[d] = '0;
            if (p.code == OUTCOME_TIMEOUT)
                dev_timeout_total[d] += 1;
            else
                dev_exception_total[d] += 1;
            if (dev_online[d] && dev_fail_run[d] >= {16'd0, offline_limit})
            begin
                dev_online[d] = 1'b0;
                dev_mask[d] = '0;
                h.fall = 1'b1;
            end
        end
        h.online = dev_online[d];
        h.failure_run = dev_fail_run[d];
        h.success_run = dev_pass_run[d];
        h.success_total = dev_pass_total[d];
        h.failure_total = dev_fail_total[d];
        h.timeout_total = dev_timeout_total[d];
        h.exception_total = dev_exception_total[d];
        h.mask = dev_mask[d];
        return h;
    endfunction

    function automatic string describe(health_t h);
        return $sformatf({"online=%0d rise=%0d fall=%0d frun=%0d srun=%0d stot=%0d ",
                          "ftot=%0d ttot=%0d etot=%0d mask=%02h"},
                         h.online, h.rise, h.fall, h.failure_run, h.success_run,
                         h.success_total, h.failure_total, h.timeout_total,
                         h.exception_total, h.mask);
    endfunction

    // Counts a failure; only the first ten are printed.
    task automatic flag_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Input driver: records each accepted transaction and presents the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_health.push_back(predict_health(current_poll));
            if (!in_valid || in_ready)
            begin
                if (pending_polls.size() != 0 && (steady || $urandom_range(0, 99) >= 25))
                begin
                    current_poll = pending_polls.pop_front();
                    in_valid <= 1'b1;
                    device_index <= current_poll.dev;
                    channel_index <= current_poll.chan;
                    outcome <= current_poll.code;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each result transaction and stalls at random.
    always @(posedge clk)
    begin
        health_t seen;
        health_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {device_online, became_online, went_offline, failure_run,
                        success_run, success_total, failure_total, timeout_total,
                        exception_total, channel_valid_mask};
                if (expected_health.size() == 0)
                begin
                    flag_fault({"unexpected result: ", describe(seen)});
                end
                else
                begin
                    want = expected_health.pop_front();
                    if (seen !== want)
                        flag_fault({"result mismatch\n  expected: ", describe(want),
                                    "\n  actual:   ", describe(seen)});
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic queue_poll(int dev, int chan, logic [1:0] code);
        poll_t p;
        p.dev = DEV_IDX_W'(dev);
        p.chan = CHAN_IDX_W'(chan);
        p.code = code;
        pending_polls.push_back(p);
    endtask

    // Mostly runs of successes or failures on one device, some long enough to cross
    // limits of up to six, with some single random reports mixed in.
    task automatic queue_random_polls(int count);
        int         queued;
        int         kind;
        int         dev;
        int         run_len;
        logic [1:0] code;
        queued = 0;
        while (queued < count)
        begin
            kind = $urandom_range(0, 9);
            dev = $urandom_range(0, NUM_DEVICES - 1);
            if (kind < 8)
            begin
                if (kind < 4)
                    run_len = $urandom_range(1, ((recovery_limit > 6) ? 6 : recovery_limit) + 1);
                else
                    run_len = $urandom_range(1, ((offline_limit > 6) ? 6 : offline_limit) + 1);
                for (int i = 0; i < run_len; i++)
                begin
                    if (kind < 4)
                        code = OUTCOME_SUCCESS;
                    else
                        code = 2'($urandom_range(OUTCOME_TIMEOUT, OUTCOME_SPARE));
                    queue_poll(dev, $urandom_range(0, 7), code);
                end
                queued += run_len;
            end
            else
            begin
                queue_poll(dev, $urandom_range(0, 7), 2'($urandom_range(0, 3)));
                queued++;
            end
        end
    endtask

    // Waits until every report is accepted and every result has arrived.
    task automatic wait_idle();
        while (pending_polls.size() != 0 || in_valid || expected_health.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_transfer(logic write, reg_index_t idx, logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Writes one limit register, reads it back and updates the local copy.
    task automatic write_limit(reg_index_t idx, logic [LIMIT_W-1:0] value);
        logic [APB_DW-1:0] rdata;
        apb_transfer(1'b1, idx, {16'd0, value}, rdata);
        if (idx == REG_OFFLINE_FAILURE_LIMIT)
            offline_limit = value;
        else
            recovery_limit = value;
        apb_transfer(1'b0, idx, '0, rdata);
        if (rdata[LIMIT_W-1:0] !== value)
            flag_fault($sformatf("register %s read back %04h, expected %04h",
                                 idx.name(), rdata[LIMIT_W-1:0], value));
    endtask

    task automatic set_limits(logic [LIMIT_W-1:0] off_value, logic [LIMIT_W-1:0] rec_value);
        wait_idle();
        write_limit(REG_OFFLINE_FAILURE_LIMIT, off_value);
        write_limit(REG_RECOVERY_SUCCESS_LIMIT, rec_value);
    endtask

    // Test sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limits: recovery on the first success, offline on the third failure,
        // every outcome code, spare code as an exception, both ends of each index.
        queue_poll(0, 0, OUTCOME_SUCCESS);
        queue_poll(0, 7, OUTCOME_SUCCESS);
        queue_poll(0, 1, OUTCOME_TIMEOUT);
        queue_poll(0, 2, OUTCOME_EXCEPTION);
        queue_poll(0, 3, OUTCOME_SPARE);
        queue_poll(0, 4, OUTCOME_SUCCESS);
        queue_poll(7, 5, OUTCOME_TIMEOUT);
        queue_poll(7, 6, OUTCOME_SPARE);
        queue_poll(7, 7, OUTCOME_SUCCESS);
        queue_poll(7, 7, OUTCOME_SUCCESS);
        queue_poll(7, 0, OUTCOME_TIMEOUT);
        queue_poll(7, 0, OUTCOME_EXCEPTION);
        queue_poll(7, 0, OUTCOME_TIMEOUT);
        queue_poll(7, 0, OUTCOME_TIMEOUT);
        queue_poll(3, 3, OUTCOME_SUCCESS);
        queue_poll(5, 2, OUTCOME_EXCEPTION);
        queue_poll(4, 6, OUTCOME_SUCCESS);
        queue_random_polls(140);

        // Zero limits: every qualifying report flips the online flag, while a
        // failure on an offline device still leaves it offline.
        set_limits(16'd0, 16'd0);
        queue_poll(1, 1, OUTCOME_TIMEOUT);
        queue_poll(1, 1, OUTCOME_SUCCESS);
        queue_poll(1, 2, OUTCOME_TIMEOUT);
        queue_poll(1, 3, OUTCOME_SUCCESS);
        queue_random_polls(60);

        // Largest limits: no device changes its online state.
        set_limits(16'hFFFF, 16'hFFFF);
        queue_random_polls(60);

        // Mid-range limits with both sides running without gaps.
        set_limits(16'd2, 16'd4);
        steady = 1'b1;
        queue_random_polls(120);

        set_limits(16'd1, 16'd2);
        steady = 1'b0;
        queue_random_polls(60);

        wait_idle();
        repeat (5) @(posedge clk);
        if (fault_count == 0)
            $display("slave_link_health_tracker_core test passed");
        else
            $display("slave_link_health_tracker_core test failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2000000;
        $display("slave_link_health_tracker_core test failed");
        $finish;
    end

endmodule
